// ===== design/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg
// Types, constants and helper functions of the LSB-first frame CRC appender.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int unsigned CrcW   = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CrcW-1:0]   CrcPoly  = 16'h1021;
  localparam logic [CountW-1:0] CountSat = 5'd31;

  // Reset values of the configuration registers
  localparam logic [CrcW-1:0]   CrcInitRst  = 16'h0000;
  localparam logic [CountW-1:0] CrcSpanRst  = 5'd6;
  localparam logic [CountW-1:0] MaxBytesRst = 5'd10;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCrcInit  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCrcSpan  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxBytes = 2'd2;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       is_crc;
    logic       frame_end;
  } result_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // One byte of CRC-16, MSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/lfc_in_if.sv =====
// ----------------------------------------------------------------------------
// lfc_in_if
// Input channel: one payload byte and its end-of-frame mark per transaction.
// ----------------------------------------------------------------------------
interface lfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/lfc_out_if.sv =====
// ----------------------------------------------------------------------------
// lfc_out_if
// Output channel: one line byte with its CRC and frame-end marks.
// ----------------------------------------------------------------------------
interface lfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       is_crc;
  logic       frame_end;

  modport source (output valid, output line_byte, output is_crc, output frame_end,
                  input ready);
  modport sink   (input valid, input line_byte, input is_crc, input frame_end,
                  output ready);
endinterface

// ===== design/lsb_first_frame_crc_appender.sv =====
// ----------------------------------------------------------------------------
// lsb_first_frame_crc_appender
// Bit-reverses payload bytes for LSB-first transmission and appends a
// CRC-16 (poly 0x1021, MSB first) of the leading crc_span bytes per frame.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  -------   ---  ------------   -------------------------------------
//  in_i      in   valid/ready    data_byte[7:0], last_byte
//  out_o     out  valid/ready    line_byte[7:0], is_crc, frame_end
//  cfg       in   cfg_we_i       cfg_idx_i[1:0], cfg_data_i[15:0]
//
//  Cycles: a byte is processed in the cycle it is accepted; its results land
//  in a four-entry result store and leave one per cycle from its head while
//  out_o.ready is high; then the sustained rate is one input byte per cycle;
//  the byte marked last yields up to three results, so each frame ends in
//  two CRC bytes. Input is taken while at most one result remains after
//  this cycle's pop, so one waiting result never blocks the next byte.
//  Reset: asynchronous, clears the store, the frame counter and the CRC and
//  loads the register defaults (crc_init 0, crc_span 6, max_bytes 10).
//  Stalls: out_o.ready low holds the head result; in_i.ready drops once the
//  store could not take three more results.
//
module lsb_first_frame_crc_appender #(
  parameter int unsigned MAX_FRAME_BYTES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfc_pkg::CrcW-1:0]     cfg_data_i,
  lfc_in_if.sink                       in_i,
  lfc_out_if.source                    out_o
);
  import lfc_pkg::*;

  localparam int unsigned Depth = 4;
  localparam logic [6:0]  MaxFrame = 7'(MAX_FRAME_BYTES);

  // Configuration registers
  logic [CrcW-1:0]   crc_init_q;
  logic [CountW-1:0] crc_span_q;
  logic [CountW-1:0] max_bytes_q;

  // Frame state
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;

  // Result store: head at entry 0
  result_t    ent_q [Depth];
  result_t    ent_d [Depth];
  result_t    shf   [Depth];
  logic [2:0] cnt_q, cnt_d, cnt_pop;

  logic            accept, pop, emit;
  logic [CrcW-1:0] crc_cur, crc_new;
  result_t         res [3];
  logic [2:0]      n_res, off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q  <= CrcInitRst;
      crc_span_q  <= CrcSpanRst;
      max_bytes_q <= MaxBytesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCrcInit:  crc_init_q  <= cfg_data_i;
        CfgCrcSpan:  crc_span_q  <= cfg_data_i[CountW-1:0];
        CfgMaxBytes: max_bytes_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign pop          = out_o.valid && out_o.ready;
  assign cnt_pop      = cnt_q - {2'b00, pop};
  assign in_i.ready   = (cnt_pop <= 3'd1);
  assign accept       = in_i.valid && in_i.ready;

  // Per-byte work: CRC update, drop decision, result list
  always_comb begin
    crc_cur = (count_q == '0) ? crc_init_q : crc_q;
    crc_new = (count_q < crc_span_q) ? crc_byte(crc_cur, in_i.data_byte) : crc_cur;
    emit    = (count_q < max_bytes_q) && ({2'b00, count_q} < MaxFrame);

    res[0] = '{line_byte: flip8(in_i.data_byte), is_crc: 1'b0, frame_end: 1'b0};
    res[1] = '{line_byte: flip8(crc_new[15:8]), is_crc: 1'b1, frame_end: 1'b0};
    res[2] = '{line_byte: flip8(crc_new[7:0]), is_crc: 1'b1, frame_end: 1'b1};
    if (!emit) begin
      res[0] = res[1];
      res[1] = res[2];
    end
    n_res = {2'b00, emit} + (in_i.last_byte ? 3'd2 : 3'd0);

    crc_d   = crc_q;
    count_d = count_q;
    if (accept) begin
      if (in_i.last_byte) begin
        crc_d   = crc_init_q;
        count_d = '0;
      end else begin
        crc_d   = crc_new;
        count_d = (count_q < CountSat) ? count_q + 5'd1 : count_q;
      end
    end
  end

  // Store update: shift on pop, then append new results behind the survivors
  always_comb begin
    off = '0;
    for (int i = 0; i < Depth; i++) begin
      shf[i] = (pop && (i < Depth - 1)) ? ent_q[(i + 1) % Depth] : ent_q[i];
    end
    for (int i = 0; i < Depth; i++) begin
      ent_d[i] = shf[i];
      off      = 3'(i) - cnt_pop;
      if (accept && (3'(i) >= cnt_pop) && (off < n_res)) begin
        ent_d[i] = res[off[1:0]];
      end
    end
    cnt_d = cnt_pop + (accept ? n_res : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInitRst;
      count_q <= '0;
      cnt_q   <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.line_byte = ent_q[0].line_byte;
  assign out_o.is_crc    = ent_q[0].is_crc;
  assign out_o.frame_end = ent_q[0].frame_end;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(Depth))
    else $error("result store overfilled");

  a_end_is_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_end |-> out_o.is_crc)
    else $error("frame end on a payload byte");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_byte |=> count_q == '0 && out_o.valid)
    else $error("frame state not restarted after last byte");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.line_byte))
    else $error("head result changed under stall");

endmodule

// ===== tb/lfc_line_checker.sv =====
// ----------------------------------------------------------------------------
// lfc_line_checker
// Watches the byte and line channels and the register port of the LSB-first
// frame CRC appender, predicts every line byte from the bytes taken in, and
// compares each line byte that leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
module lfc_line_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfc_pkg::CrcW-1:0]    cfg_data_i,
  lfc_in_if                           in_mon,
  lfc_out_if                          out_mon,
  output int unsigned                 pending_o,
  output int unsigned                 mismatch_o
);
  import lfc_pkg::*;

  logic [CrcW-1:0]   crc_init_q;
  logic [CountW-1:0] crc_span_q;
  logic [CountW-1:0] max_bytes_q;
  logic [CrcW-1:0]   crc_run;
  logic [CountW-1:0] frame_pos;
  result_t           line_bytes_due[$];
  int unsigned       due_cnt = 0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       lines_seen = 0;

  assign pending_o  = due_cnt;
  assign mismatch_o = mismatch_cnt;

  function automatic logic [7:0] reverse_bits(input logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  // Bit-serial CCITT update, data MSB first
  function automatic logic [CrcW-1:0] crc16_update(input logic [CrcW-1:0] crc,
                                                   input logic [7:0]      d);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[CrcW-1] ^ d[i];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  task automatic report(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic predict_line_bytes(input logic [7:0] d, input logic last);
    logic [CrcW-1:0] crc;
    crc = (frame_pos == '0) ? crc_init_q : crc_run;
    if (frame_pos < crc_span_q) crc = crc16_update(crc, d);
    if (frame_pos < max_bytes_q && frame_pos < MAX_FRAME_BYTES)
      line_bytes_due.push_back(result_t'{reverse_bits(d), 1'b0, 1'b0});
    if (frame_pos != CountSat) frame_pos = frame_pos + 1'b1;
    crc_run = crc;
    if (last) begin
      line_bytes_due.push_back(result_t'{reverse_bits(crc[15:8]), 1'b1, 1'b0});
      line_bytes_due.push_back(result_t'{reverse_bits(crc[7:0]), 1'b1, 1'b1});
      crc_run   = crc_init_q;
      frame_pos = '0;
    end
  endtask

  task automatic check_line_byte(input result_t got);
    result_t want;
    if (line_bytes_due.size() == 0) begin
      report($sformatf("line byte %0d: %02h arrived with nothing expected",
                       lines_seen, got.line_byte));
    end else begin
      want = line_bytes_due.pop_front();
      if (got.line_byte != want.line_byte)
        report($sformatf("line byte %0d: line_byte %02h, want %02h",
                         lines_seen, got.line_byte, want.line_byte));
      if (got.is_crc != want.is_crc)
        report($sformatf("line byte %0d: is_crc %0b, want %0b",
                         lines_seen, got.is_crc, want.is_crc));
      if (got.frame_end != want.frame_end)
        report($sformatf("line byte %0d: frame_end %0b, want %0b",
                         lines_seen, got.frame_end, want.frame_end));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q  = CrcInitRst;
      crc_span_q  = CrcSpanRst;
      max_bytes_q = MaxBytesRst;
      crc_run     = CrcInitRst;
      frame_pos   = '0;
      line_bytes_due.delete();
      due_cnt <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_line_bytes(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        check_line_byte(result_t'{out_mon.line_byte, out_mon.is_crc, out_mon.frame_end});
        lines_seen++;
      end
      // a write takes effect for the next transaction
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCrcInit:  crc_init_q  = cfg_data_i;
          CfgCrcSpan:  crc_span_q  = cfg_data_i[CountW-1:0];
          CfgMaxBytes: max_bytes_q = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      due_cnt <= line_bytes_due.size();
    end
  end

endmodule

// ===== tb/tb_lsb_first_frame_crc_appender.sv =====
// ----------------------------------------------------------------------------
// tb_lsb_first_frame_crc_appender
// Drives payload frames and register settings into the LSB-first frame CRC
// appender with random stalls on both channels; the line checker predicts
// and compares every line byte, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_lsb_first_frame_crc_appender;
  import lfc_pkg::*;

  localparam int unsigned MaxFrameBytes = 16;
  localparam int unsigned RandomItems   = 75;   // random part stops past this
  localparam int unsigned CalmAfter     = 55;   // no idling from here on
  localparam int unsigned LongHold      = 64;   // receiver hold-off, in cycles
  localparam int unsigned SettleCycles  = 4;    // block latency plus margin
  localparam int unsigned WatchdogLimit = 1000; // cycles with no transaction

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CrcW-1:0]     cfg_data;

  lfc_in_if  in_ch ();
  lfc_out_if out_ch ();

  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  int unsigned rand_items  = 0;
  int unsigned long_frames = 0;
  logic        calm          = 1'b0;  // suppresses idling on both sides
  logic        long_hold_req = 1'b0;  // raised by stimulus, cleared by sink
  logic        holding       = 1'b0;  // sink is in its long hold-off

  always #5 clk_i = ~clk_i;

  lsb_first_frame_crc_appender #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  lfc_line_checker #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending_o  (pending),
    .mismatch_o (mismatches)
  );

  // --------------------------------------------------------------------------
  // Byte channel helpers. valid is never dropped at the edge that ends a
  // transaction unless the next step is a gap, so back-to-back bytes keep it
  // high with a single assignment per time step.
  // --------------------------------------------------------------------------

  // Offer one byte and return at the edge where it is taken
  task automatic send_byte(input logic [7:0] d, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pause_send(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every predicted line byte has left, then keep the input idle
  // through the SettleCycles wait before a write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // All three registers in consecutive cycles; we stays high throughout
  task automatic set_config(input logic [CrcW-1:0] init, input logic [CrcW-1:0] span,
                            input logic [CrcW-1:0] maxb);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgCrcInit;
    cfg_data <= init;
    @(posedge clk_i);
    cfg_idx  <= CfgCrcSpan;
    cfg_data <= span;
    @(posedge clk_i);
    cfg_idx  <= CfgMaxBytes;
    cfg_data <= maxb;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Random frame content; last is set only on the final byte
  task automatic send_frame(input int unsigned len);
    logic [7:0] d;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      send_byte(d, i == len - 1);
      rand_items++;
      if (!calm && $urandom_range(0, 4) == 0) pause_send($urandom_range(1, 17));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    logic [CrcW-1:0] init_v;
    logic [CrcW-1:0] span_v;
    logic [CrcW-1:0] maxb_v;
    int unsigned     frames;
    int unsigned     len;
    logic            first_phase;

    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CfgCrcInit;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults (init 0, span 6, max 10).
    // Short frame with extreme bytes: CRC covers only the four given.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    // One-byte frame
    send_byte(8'hA5, 1'b1);
    // Twelve bytes: past crc_span for the CRC and past max_bytes for output,
    // the last one is dropped but still closes the frame.
    for (int unsigned i = 0; i < 12; i++) send_byte(8'(17 * i + 3), i == 11);
    drain();

    // Zero span and zero max: only the two CRC bytes, both equal to init
    set_config(16'hFFFF, 16'd0, 16'd0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();

    // Register maximums: span and max beyond the frame limit
    set_config(16'h1D0F, 16'd31, 16'd31);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hE7, 1'b0);
    send_byte(8'h7E, 1'b1);
    drain();

    // Random phases: a fresh register setting each, drained before the next
    first_phase = 1'b1;
    while (rand_items < RandomItems) begin
      case ($urandom_range(0, 3))
        0:       init_v = 16'h0000;
        1:       init_v = 16'hFFFF;
        default: init_v = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       span_v = 16'd0;
        1:       span_v = 16'd16;
        2:       span_v = 16'd31;
        default: span_v = 16'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       maxb_v = 16'd1;
        1:       maxb_v = 16'd16;
        2:       maxb_v = $urandom_range(0, 1) ? 16'd31 : 16'd0;
        default: maxb_v = 16'($urandom_range(1, 16));
      endcase
      set_config(init_v, span_v, maxb_v);

      if (first_phase) begin
        // Receiver holds off while a long frame keeps coming: the result
        // store fills and the block must stall its input.
        long_hold_req = 1'b1;
        while (!holding) @(posedge clk_i);
        send_frame(16);
        first_phase = 1'b0;
      end

      frames = $urandom_range(3, 6);
      for (int unsigned f = 0; f < frames; f++) begin
        calm = (rand_items >= CalmAfter);
        // Up to two frames run past the counter's saturation point
        if (long_frames < 2 && $urandom_range(0, 9) == 0) begin
          len = $urandom_range(32, 36);
          long_frames++;
        end else begin
          len = $urandom_range(1, 20);
        end
        send_frame(len);
      end
      // Sender pauses here until every expected line byte has come
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Line channel receiver: random ready bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        holding = 1'b1;
        repeat (LongHold) @(posedge clk_i);
        holding       = 1'b0;
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== lsb_first_frame_crc_appender.f =====
design/lfc_pkg.sv
design/lfc_in_if.sv
design/lfc_out_if.sv
design/lsb_first_frame_crc_appender.sv
tb/lfc_line_checker.sv
tb/tb_lsb_first_frame_crc_appender.sv
